>>> hdl/lpht_pkg.sv
// Package for the linear-probing hash table: field widths, status and action codes,
// hash constants and the store write-control struct.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lpht_pkg;

    // Fixed widths of the request and response words.
    localparam int ACTION_W    = 2;
    localparam int REQ_KEY_W   = 64;
    localparam int REQ_VALUE_W = 64;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 10;

    // djb2 hash: h = h * 33 + byte, 64-bit wrapping.
    localparam int              HASH_W    = 64;
    localparam logic [63:0]     DJB_SEED  = 64'd5381;
    localparam int              DJB_SHIFT = 5;

    // The slot reduction for a depth that is not a power of two takes this many
    // hash bits per cycle.
    localparam int MOD_DIGIT_W = 4;

    // Request actions. The fourth code is answered as not found and changes nothing.
    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEL  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_ZERO_KEY  = 3'd6
    } t_status;

    typedef struct packed {
        logic key_we;
        logic val_we;
    } t_wr_ctl;

endpackage

`default_nettype wire

>>> hdl/lpht_req_if.sv
// Request channel of the hash table: valid/ready handshake carrying action, key and value.
// Depends on lpht_pkg for the field widths.
`default_nettype none

interface lpht_req_if;
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [REQ_KEY_W-1:0]   key;
    logic [REQ_VALUE_W-1:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/lpht_rsp_if.sv
// Response channel of the hash table: valid/ready handshake carrying status, value and slot.
// Depends on lpht_pkg for the field widths.
`default_nettype none

interface lpht_rsp_if;
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [REQ_VALUE_W-1:0] read_value;
    logic [SLOT_OUT_W-1:0]  slot_index;

    modport source (output valid, output status, output read_value, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input read_value, input slot_index,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/lpht_hash.sv
// Home-slot unit: djb2 over the key bytes, one byte per cycle, then the hash
// reduced modulo the table depth. Depends on lpht_pkg.
`default_nettype none

module lpht_hash #(
    parameter  int TABLE_DEPTH = 1024,
    parameter  int KEY_BYTES   = 8,
    localparam int KEY_W       = 8 * KEY_BYTES,
    localparam int SLOT_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [KEY_W-1:0]  i_key,
    output logic                   o_done,
    output logic [SLOT_W-1:0]      o_slot
);
    import lpht_pkg::*;

    localparam bit IS_POW2   = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam int BC_W      = $clog2(KEY_BYTES + 1);
    localparam int RED_STEPS = HASH_W / MOD_DIGIT_W;
    localparam int RC_W      = $clog2(RED_STEPS);
    localparam int T_W       = SLOT_W + MOD_DIGIT_W;

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_MIX  = 3'b010,
        H_RED  = 3'b100
    } t_hstate;

    t_hstate           r_state;
    logic [HASH_W-1:0] r_h;
    logic [KEY_W-1:0]  r_ks;
    logic [BC_W-1:0]   r_bcnt;
    logic [SLOT_W-1:0] r_rem;
    logic [RC_W-1:0]   r_rcnt;
    logic              r_done;
    logic [SLOT_W-1:0] r_slot;

    logic [HASH_W-1:0] n_h_mix;
    logic [T_W-1:0]    n_t;
    logic [SLOT_W-1:0] n_rem;

    assign n_h_mix = (r_h << DJB_SHIFT) + r_h + HASH_W'(r_ks[7:0]);

    // Long division one digit at a time: the running remainder stays below the
    // depth, so four conditional subtractions of 8, 4, 2 and 1 times the depth
    // bring the extended remainder back into range.
    always_comb begin
        n_t = {r_rem, r_h[HASH_W-1 -: MOD_DIGIT_W]};
        for (int k = MOD_DIGIT_W - 1; k >= 0; k--) begin
            if (n_t >= (T_W'(TABLE_DEPTH) << k)) begin
                n_t = n_t - (T_W'(TABLE_DEPTH) << k);
            end
        end
        n_rem = n_t[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_h     <= DJB_SEED;
                        r_ks    <= i_key;
                        r_bcnt  <= '0;
                        r_state <= H_MIX;
                    end
                end
                H_MIX: begin
                    r_h    <= n_h_mix;
                    r_ks   <= r_ks >> 8;
                    r_bcnt <= r_bcnt + 1'b1;
                    if (r_bcnt == BC_W'(KEY_BYTES - 1)) begin
                        if (IS_POW2) begin
                            r_slot  <= n_h_mix[SLOT_W-1:0];
                            r_done  <= 1'b1;
                            r_state <= H_IDLE;
                        end else begin
                            r_rem   <= '0;
                            r_rcnt  <= '0;
                            r_state <= H_RED;
                        end
                    end
                end
                H_RED: begin
                    r_rem  <= n_rem;
                    r_h    <= r_h << MOD_DIGIT_W;
                    r_rcnt <= r_rcnt + 1'b1;
                    if (r_rcnt == RC_W'(RED_STEPS - 1)) begin
                        r_slot  <= n_rem;
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_slot = r_slot;

endmodule

`default_nettype wire

>>> hdl/lpht_store.sv
// Key and value memories of the hash table: one write port and one read port
// each, read data registered. Depends on lpht_pkg for the write-control struct.
`default_nettype none

module lpht_store #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_W       = 64,
    parameter int VAL_W       = 64,
    parameter int SLOT_W      = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rd_en,
    input  wire logic [SLOT_W-1:0]     i_rd_addr,
    output logic [KEY_W-1:0]           o_rd_key,
    output logic [VAL_W-1:0]           o_rd_val,
    input  wire lpht_pkg::t_wr_ctl     i_wr,
    input  wire logic [SLOT_W-1:0]     i_wr_addr,
    input  wire logic [KEY_W-1:0]      i_wr_key,
    input  wire logic [VAL_W-1:0]      i_wr_val
);
    import lpht_pkg::*;

    logic [KEY_W-1:0] r_key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] r_val_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
        if (i_rd_en) begin
            r_rd_val <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_val = r_rd_val;

endmodule

`default_nettype wire

>>> hdl/linear_probe_hash_table.sv
// Top level of the linear-probing hash table: request/response control, probe walk
// and output register. Depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_hash, lpht_store.
`default_nettype none

// A key-value table with open addressing. Each request word carries a set, get or
// delete with a key and, for a set, a value; each one yields exactly one response word
// with a status, the value found by a get and the slot touched. The home slot is the
// djb2 hash of the low KEY_BYTES key bytes modulo TABLE_DEPTH, and probing walks forward
// with wrap, stopping at the key, at an empty slot (a zero key) or once every slot has
// been visited. Deletes leave no tombstone, so entries further along a chain can become
// unreachable. Requests are served one at a time: the key is hashed byte by byte, with a
// reduction step added when TABLE_DEPTH is not a power of two, and then the probe walk
// reads the key memory one slot after another through its single read port. Unused
// actions and zero keys skip the hash and the walk and go straight to the response. After
// reset the key memory is swept to zero, one slot per cycle; no request is taken until
// the sweep ends. A finished response waits in an output register, so a new request
// can be taken while the previous response word is still stalled.

module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpht_req_if.sink    i_req,
    lpht_rsp_if.source  o_rsp
);
    import lpht_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int VAL_W  = 8 * VALUE_BYTES;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    t_state              r_state;
    logic [SLOT_W-1:0]   r_clr_addr;
    logic                r_out_vld;

    // Request being served.
    logic [ACTION_W-1:0] r_action;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_val;

    // Probe walk: r_chk_slot is the slot whose key arrives from the memory this cycle,
    // r_iss_slot the slot being read for the next cycle, r_cnt the slots already passed.
    logic [SLOT_W-1:0]   r_chk_slot;
    logic [SLOT_W-1:0]   r_iss_slot;
    logic [SLOT_W-1:0]   r_cnt;

    t_status             r_res_status;
    logic [VAL_W-1:0]    r_res_val;
    logic [SLOT_W-1:0]   r_res_slot;

    t_status             r_out_status;
    logic [VAL_W-1:0]    r_out_val;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                w_acc;
    logic                w_hash_start;
    logic                w_hash_done;
    logic [SLOT_W-1:0]   w_hash_slot;
    logic [KEY_W-1:0]    n_key;
    logic [VAL_W-1:0]    n_val;

    logic                w_rd_en;
    logic [SLOT_W-1:0]   w_rd_addr;
    logic [KEY_W-1:0]    w_rd_key;
    logic [VAL_W-1:0]    w_rd_val;
    t_wr_ctl             w_wr;
    logic [SLOT_W-1:0]   w_wr_addr;
    logic [KEY_W-1:0]    w_wr_key;

    logic                w_match;
    logic                w_empty;
    logic                n_fin;
    logic                n_hit_slot;
    t_status             n_status;
    t_wr_ctl             n_wr;
    logic                n_out_free;

    // Only the low KEY_BYTES and VALUE_BYTES bytes take part.
    assign n_key = i_req.key[KEY_W-1:0];
    assign n_val = i_req.value[VAL_W-1:0];

    assign i_req.ready  = (r_state == S_IDLE);
    assign w_acc        = i_req.valid && i_req.ready;
    assign w_hash_start = w_acc && (i_req.action != ACT_NONE) && (n_key != '0);
    assign n_out_free   = !r_out_vld || o_rsp.ready;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    lpht_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (n_key),
        .o_done  (w_hash_done),
        .o_slot  (w_hash_slot)
    );

    // The home slot is read in the cycle the hash completes; during the walk the
    // following slot is read every cycle so that one slot is checked per cycle.
    // The extra read after the walk stops is simply discarded.
    assign w_rd_en   = (r_state == S_HASH && w_hash_done) || (r_state == S_PROBE);
    assign w_rd_addr = (r_state == S_HASH) ? w_hash_slot : r_iss_slot;

    lpht_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_W       (KEY_W),
        .VAL_W       (VAL_W),
        .SLOT_W      (SLOT_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_key  (w_rd_key),
        .o_rd_val  (w_rd_val),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .i_wr_key  (w_wr_key),
        .i_wr_val  (r_val)
    );

    assign w_match = (w_rd_key == r_key);
    assign w_empty = (w_rd_key == '0);

    // Decision on the slot being checked. The request key is never zero here, so a
    // match and an empty slot cannot both hold.
    always_comb begin
        n_fin      = 1'b0;
        n_hit_slot = 1'b0;
        n_status   = ST_NOT_FOUND;
        n_wr       = '0;
        if (w_match) begin
            n_fin      = 1'b1;
            n_hit_slot = 1'b1;
            case (r_action)
                ACT_SET: begin
                    n_wr.val_we = 1'b1;
                    n_status    = ST_UPDATED;
                end
                ACT_GET: n_status = ST_FOUND;
                default: begin
                    n_wr.key_we = 1'b1;
                    n_status    = ST_DELETED;
                end
            endcase
        end else if (w_empty) begin
            n_fin = 1'b1;
            if (r_action == ACT_SET) begin
                n_hit_slot  = 1'b1;
                n_wr.key_we = 1'b1;
                n_wr.val_we = 1'b1;
                n_status    = ST_INSERTED;
            end
        end else if (r_cnt == LAST_SLOT) begin
            // Every slot has been visited without a match or a free slot.
            n_fin    = 1'b1;
            n_status = (r_action == ACT_SET) ? ST_FULL : ST_NOT_FOUND;
        end
    end

    // A delete writes a zero key; the clearing sweep does the same over every slot.
    always_comb begin
        w_wr      = '0;
        w_wr_addr = r_chk_slot;
        w_wr_key  = w_match ? '0 : r_key;
        if (r_state == S_CLEAR) begin
            w_wr.key_we = 1'b1;
            w_wr_addr   = r_clr_addr;
            w_wr_key    = '0;
        end else if (r_state == S_PROBE) begin
            w_wr = n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_state == S_DONE && n_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= w_hash_start ? S_HASH : S_DONE;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (n_fin) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_action     <= i_req.action;
            r_key        <= n_key;
            r_val        <= n_val;
            r_res_val    <= '0;
            r_res_slot   <= '0;
            r_res_status <= (i_req.action == ACT_NONE) ? ST_NOT_FOUND : ST_ZERO_KEY;
        end
        if (r_state == S_HASH && w_hash_done) begin
            r_chk_slot <= w_hash_slot;
            r_iss_slot <= next_slot(w_hash_slot);
            r_cnt      <= '0;
        end
        if (r_state == S_PROBE) begin
            if (n_fin) begin
                r_res_status <= n_status;
                if (n_hit_slot) begin
                    r_res_slot <= r_chk_slot;
                end
                if (w_match && r_action == ACT_GET) begin
                    r_res_val <= w_rd_val;
                end
            end else begin
                r_chk_slot <= r_iss_slot;
                r_iss_slot <= next_slot(r_iss_slot);
                r_cnt      <= r_cnt + 1'b1;
            end
        end
        if (r_state == S_DONE && n_out_free) begin
            r_out_status <= r_res_status;
            r_out_val    <= r_res_val;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = REQ_VALUE_W'(r_out_val);
    assign o_rsp.slot_index = SLOT_OUT_W'(r_out_slot);

`ifndef SYNTHESIS
    // The hash unit only completes while the controller waits for it.
    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> (r_state == S_HASH))
        else $error("hash completed outside the hash wait state");

    // The memories are written only by the clearing sweep and by the probe walk.
    a_write_in_clear_or_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.key_we || w_wr.val_we) |-> (r_state == S_CLEAR || r_state == S_PROBE))
        else $error("memory written outside the clearing sweep or probe walk");

    // An unused action is answered straight away as not found.
    a_unused_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.action == ACT_NONE) |=>
            (r_state == S_DONE && r_res_status == ST_NOT_FOUND))
        else $error("unused action not answered as not found");

    // An insert leaves the probe walk only after writing both key and value.
    a_insert_wrote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) == S_PROBE && r_res_status == ST_INSERTED)
            |-> $past(w_wr.key_we && w_wr.val_we))
        else $error("insert reported without key and value write");
`endif

endmodule

`default_nettype wire

>>> tb/linear_probe_hash_table_tb.sv
// Self-checking testbench for linear_probe_hash_table: set, get and delete requests are
// driven over the request channel and every response word is checked against a shadow table.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if and the block's RTL.

module linear_probe_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    // Geometry of the block under test. The shadow table below is sized from these.
    localparam int TB_DEPTH       = 1024;
    localparam int TB_KEY_BYTES   = 8;
    localparam int TB_VALUE_BYTES = 8;

    localparam logic [63:0] KEY_MASK   = (TB_KEY_BYTES == 8) ? '1 :
                                         ((64'd1 << (8 * TB_KEY_BYTES)) - 64'd1);
    localparam logic [63:0] VALUE_MASK = (TB_VALUE_BYTES == 8) ? '1 :
                                         ((64'd1 << (8 * TB_VALUE_BYTES)) - 64'd1);

    // The table fill at the end adds roughly a thousand requests of its own.
    localparam int RANDOM_ITEMS  = 880;
    localparam int MAX_REPORTS   = 10;
    // One response may walk the whole table behind a stalled receiver, so the drain
    // bound is generous; the settle time covers one short request after the last word.
    localparam int DRAIN_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;

    // One response word as the block should produce it.
    typedef struct packed {
        t_status                 status;
        logic [REQ_VALUE_W-1:0]  read_value;
        logic [SLOT_OUT_W-1:0]   slot_index;
    } t_lookup_word;

    // Behaviour of the response side between long hold-offs.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_CHOPPY,
        RX_STARVED
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();

    linear_probe_hash_table #(
        .TABLE_DEPTH (TB_DEPTH),
        .KEY_BYTES   (TB_KEY_BYTES),
        .VALUE_BYTES (TB_VALUE_BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the table. The value entries start at zero here, but the stimulus
    // never reads a value entry whose key has not been written by a set.
    logic [63:0]  shadow_keys   [TB_DEPTH];
    logic [63:0]  shadow_values [TB_DEPTH];
    int unsigned  shadow_fill;

    // Responses still owed by the block, oldest first.
    t_lookup_word pending_words [$];
    t_lookup_word head_word;

    int unsigned  status_tally [7];
    int unsigned  requests_sent;
    int unsigned  words_checked;
    int unsigned  mismatch_count;

    int unsigned  tx_burst_left;
    int unsigned  rx_hold_request;
    int unsigned  rx_hold_left;
    int unsigned  rx_mode_left;
    t_rx_mode     rx_mode;

    // ------------------------------------------------------------------------------------
    // Clock, and a hard limit on the length of the run.
    // ------------------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The slowest correct run is dominated by the reset sweep and the long probe walks
    // while the table fills up; this bound is several times that.
    initial begin
        #50ms;
        $display("Run limit reached with %0d responses outstanding.", pending_words.size());
        $display("** linear_probe_hash_table: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Shadow table.
    // ------------------------------------------------------------------------------------

    // djb2 over the low key bytes, byte 0 first, in 64-bit wrapping arithmetic, then
    // reduced to a slot number.
    function automatic int unsigned home_slot_of(logic [63:0] key);
        logic [63:0] h;
        h = DJB_SEED;
        for (int i = 0; i < TB_KEY_BYTES; i++)
            h = (h << DJB_SHIFT) + h + 64'(key[8*i +: 8]);
        return int'(h % 64'(TB_DEPTH));
    endfunction

    // Applies one request to the shadow table and returns the response word it must give.
    function automatic t_lookup_word predict_lookup(logic [ACTION_W-1:0] act,
                                                    logic [63:0] key_in,
                                                    logic [63:0] value_in);
        t_lookup_word w;
        logic [63:0]  key;
        logic [63:0]  val;
        int unsigned  slot;
        bit           done;
        key          = key_in & KEY_MASK;
        val          = value_in & VALUE_MASK;
        w.status     = ST_NOT_FOUND;
        w.read_value = '0;
        w.slot_index = '0;
        if (act == ACT_NONE)
            return w;
        if (key == '0) begin
            w.status = ST_ZERO_KEY;
            return w;
        end
        // Running out of slots means full for a set and a miss for the others.
        w.status = (act == ACT_SET) ? ST_FULL : ST_NOT_FOUND;
        slot     = home_slot_of(key);
        done     = 1'b0;
        for (int n = 0; n < TB_DEPTH && !done; n++) begin
            if (shadow_keys[slot] == key) begin
                done         = 1'b1;
                w.slot_index = SLOT_OUT_W'(slot);
                if (act == ACT_SET) begin
                    shadow_values[slot] = val;
                    w.status            = ST_UPDATED;
                end else if (act == ACT_GET) begin
                    w.read_value = shadow_values[slot];
                    w.status     = ST_FOUND;
                end else begin
                    shadow_keys[slot] = '0;
                    if (shadow_fill > 0)
                        shadow_fill--;
                    w.status = ST_DELETED;
                end
            end else if (shadow_keys[slot] == '0) begin
                done = 1'b1;
                if (act == ACT_SET) begin
                    shadow_keys[slot]   = key;
                    shadow_values[slot] = val;
                    shadow_fill++;
                    w.slot_index = SLOT_OUT_W'(slot);
                    w.status     = ST_INSERTED;
                end
            end else begin
                slot = (slot + 1 == TB_DEPTH) ? 0 : slot + 1;
            end
        end
        return w;
    endfunction

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        do
            k = {$urandom, $urandom} & KEY_MASK;
        while (k == '0);
        return k;
    endfunction

    // Draws keys until one lands on the wanted home slot; about TB_DEPTH tries on average.
    function automatic logic [63:0] key_homing_to(int unsigned slot);
        logic [63:0] k;
        do
            k = random_key();
        while (home_slot_of(k) != slot);
        return k;
    endfunction

    // ------------------------------------------------------------------------------------
    // Request side. Words go out in bursts of random length; between most bursts valid drops
    // for a random number of cycles. Valid is only lowered at the start of a gap, so it
    // never gets two assignments in one time step.
    // ------------------------------------------------------------------------------------
    task automatic send_request(logic [ACTION_W-1:0] act, logic [63:0] key,
                                logic [63:0] value);
        int unsigned gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.key    <= key;
        req_ch.value  <= value;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        // The word was taken at this edge, so the table moves on now.
        head_word = predict_lookup(act, key, value);
        pending_words.push_back(head_word);
        status_tally[int'(head_word.status)]++;
        requests_sent++;
    endtask

    // ------------------------------------------------------------------------------------
    // Response side. Ready follows a mode that is drawn anew whenever its run ends: always
    // ready, ready half the time, or mostly stalled. A test may ask for a long hold-off,
    // which this process counts down on its own.
    // ------------------------------------------------------------------------------------
    initial begin
        rsp_ch.ready <= 1'b0;
        rx_hold_left  = 0;
        rx_mode_left  = 0;
        rx_mode       = RX_STREAM;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request != 0) begin
                rx_hold_left    = rx_hold_request;
                rx_hold_request = 0;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 2))
                        0:       rx_mode = RX_STREAM;
                        1:       rx_mode = RX_CHOPPY;
                        default: rx_mode = RX_STARVED;
                    endcase
                end
                rx_mode_left--;
                case (rx_mode)
                    RX_STREAM:  rsp_ch.ready <= 1'b1;
                    RX_CHOPPY:  rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Response checking. Every word taken from the block is compared field by field with
    // the oldest word still owed. Only the first few failures are described in full.
    // ------------------------------------------------------------------------------------
    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t ns] mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_words.size() == 0) begin
                note_failure($sformatf("unexpected word: status %0d value %h slot %0d",
                                       rsp_ch.status, rsp_ch.read_value, rsp_ch.slot_index));
            end else begin
                head_word = pending_words.pop_front();
                if (rsp_ch.status !== head_word.status
                        || rsp_ch.read_value !== head_word.read_value
                        || rsp_ch.slot_index !== head_word.slot_index)
                    note_failure($sformatf(
                        "word %0d: status %0d/%0d value %h/%h slot %0d/%0d (want/got)",
                        words_checked, head_word.status, rsp_ch.status,
                        head_word.read_value, rsp_ch.read_value,
                        head_word.slot_index, rsp_ch.slot_index));
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // Lookups on an empty table, then insert, update and read back with the widest key
    // and value, and a key that only has its top bit set.
    task automatic test_basic_operations();
        logic [63:0] top_key;
        top_key = 64'h8000_0000_0000_0000;
        send_request(ACT_GET, '1, '0);
        send_request(ACT_DEL, '1, '0);
        send_request(ACT_SET, '1, '1);
        send_request(ACT_GET, '1, '0);
        send_request(ACT_SET, '1, '0);
        send_request(ACT_GET, '1, '1);
        send_request(ACT_SET, top_key, 64'h1);
        // A get ignores its value field, so give it one that would show through.
        send_request(ACT_GET, top_key, '1);
        send_request(ACT_DEL, top_key, '1);
        send_request(ACT_GET, top_key, '0);
    endtask

    // The reserved zero key is refused by set, get and delete, and the unused action answers
    // not found whatever the key, even one that is in the table.
    task automatic test_zero_key_and_unused_action();
        send_request(ACT_SET, '0, '1);
        send_request(ACT_GET, '0, '0);
        send_request(ACT_DEL, '0, '0);
        send_request(ACT_NONE, '0, '0);
        send_request(ACT_NONE, '1, '1);
        send_request(ACT_GET, '1, '0);
    endtask

    // Two keys share the last slot, so the second wraps round to slot 0. Deleting the
    // first breaks the chain: the second becomes unreachable, and setting it again puts
    // a fresh copy back in the last slot while the stale one stays in slot 0.
    task automatic test_wrap_and_broken_chain();
        logic [63:0] first_key;
        logic [63:0] second_key;
        first_key  = key_homing_to(TB_DEPTH - 1);
        do
            second_key = key_homing_to(TB_DEPTH - 1);
        while (second_key == first_key);
        send_request(ACT_SET, first_key, {$urandom, $urandom});
        send_request(ACT_SET, second_key, {$urandom, $urandom});
        send_request(ACT_GET, second_key, '0);
        send_request(ACT_DEL, first_key, '0);
        send_request(ACT_GET, second_key, '0);
        send_request(ACT_SET, second_key, {$urandom, $urandom});
        send_request(ACT_GET, second_key, '0);
        send_request(ACT_DEL, second_key, '0);
        send_request(ACT_DEL, second_key, '0);
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the output
    // register fills and the block has to hold its request channel off.
    task automatic test_back_pressure();
        logic [63:0] keys [8];
        foreach (keys[i])
            keys[i] = random_key();
        rx_hold_request = LONG_HOLD;
        foreach (keys[i])
            send_request(ACT_SET, keys[i], {$urandom, $urandom});
        foreach (keys[i])
            send_request(ACT_GET, keys[i], '0);
    endtask

    // Mostly well-formed traffic over a pool of keys, so that sets are followed by gets,
    // updates and deletes of the same keys. Part of the pool is packed onto a few home
    // slots at the top of the table, which builds long chains that wrap and then break.
    // The rest is misses, zero keys and the unused action.
    task automatic test_random_traffic();
        logic [63:0]         pool [$];
        logic [63:0]         key;
        logic [63:0]         value;
        logic [ACTION_W-1:0] act;
        int unsigned         pick;
        for (int i = 0; i < 40; i++)
            pool.push_back(random_key());
        for (int s = TB_DEPTH - 4; s < TB_DEPTH; s++)
            for (int i = 0; i < 4; i++)
                pool.push_back(key_homing_to(s));
        for (int i = 0; i < 8; i++)
            pool.push_back(key_homing_to(TB_DEPTH / 3));
        // Keys with a single non-zero byte, in every byte position.
        for (int b = 0; b < TB_KEY_BYTES; b++)
            pool.push_back(64'($urandom_range(1, 255)) << (8 * b));
        pool.push_back(KEY_MASK);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick  = $urandom_range(0, 99);
            key   = pool[$urandom_range(0, pool.size() - 1)];
            value = {$urandom, $urandom};
            if (pick < 40) begin
                act = ACT_SET;
            end else if (pick < 70) begin
                act = ACT_GET;
            end else if (pick < 88) begin
                act = ACT_DEL;
            end else if (pick < 94) begin
                act = ACT_NONE;
                if ($urandom_range(0, 3) == 0)
                    key = '0;
            end else begin
                key = '0;
                case ($urandom_range(0, 2))
                    0:       act = ACT_SET;
                    1:       act = ACT_GET;
                    default: act = ACT_DEL;
                endcase
            end
            // Now and then look for a key that was never stored.
            if ((act == ACT_GET || act == ACT_DEL) && $urandom_range(0, 9) == 0)
                key = random_key();
            send_request(act, key, value);
        end
    endtask

    // Fills every remaining slot with new keys, then checks that a set reports full and
    // that a get and a delete of a missing key walk the whole table and miss. Finally a
    // reachable entry is updated and deleted, and its slot is taken by the refused key.
    task automatic test_full_table();
        logic [63:0] extra_key;
        logic [63:0] kept_key;
        while (shadow_fill < TB_DEPTH)
            send_request(ACT_SET, random_key(), {$urandom, $urandom});
        extra_key = random_key();
        send_request(ACT_SET, extra_key, {$urandom, $urandom});
        send_request(ACT_GET, extra_key, '0);
        send_request(ACT_DEL, extra_key, '0);
        // A key sitting in its own home slot is always reachable.
        kept_key = '0;
        for (int s = 0; s < TB_DEPTH && kept_key == '0; s++)
            if (home_slot_of(shadow_keys[s]) == s)
                kept_key = shadow_keys[s];
        if (kept_key != '0) begin
            send_request(ACT_GET, kept_key, '0);
            send_request(ACT_SET, kept_key, {$urandom, $urandom});
            send_request(ACT_DEL, kept_key, '0);
            send_request(ACT_SET, extra_key, {$urandom, $urandom});
            send_request(ACT_GET, extra_key, '0);
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------------------
    initial begin
        int unsigned waited;
        i_rst_n       <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_NONE;
        req_ch.key    <= '0;
        req_ch.value  <= '0;
        foreach (shadow_keys[i]) begin
            shadow_keys[i]   = '0;
            shadow_values[i] = '0;
        end
        foreach (status_tally[i])
            status_tally[i] = 0;
        shadow_fill     = 0;
        requests_sent   = 0;
        words_checked   = 0;
        mismatch_count  = 0;
        tx_burst_left   = 0;
        rx_hold_request = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its key memory after reset; the first request simply waits
        // for ready.
        test_basic_operations();
        test_zero_key_and_unused_action();
        test_wrap_and_broken_chain();
        test_back_pressure();
        test_random_traffic();
        test_full_table();
        req_ch.valid <= 1'b0;

        waited = 0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_words.size() != 0) begin
            $display("%0d responses never arrived.", pending_words.size());
            $display("** linear_probe_hash_table: FAILED **");
            $finish;
        end else begin
            // Give a stray extra word time to show up before judging the run.
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            $display("Sent %0d requests and checked %0d responses, ending on a full table.",
                     requests_sent, words_checked);
            $display({"Outcomes: %0d inserted, %0d updated, %0d found, %0d missed, ",
                      "%0d deleted, %0d full, %0d zero key; %0d mismatches."},
                     status_tally[ST_INSERTED], status_tally[ST_UPDATED],
                     status_tally[ST_FOUND], status_tally[ST_NOT_FOUND],
                     status_tally[ST_DELETED], status_tally[ST_FULL],
                     status_tally[ST_ZERO_KEY], mismatch_count);
            if (mismatch_count == 0)
                $display("** linear_probe_hash_table: PASSED **");
            else
                $display("** linear_probe_hash_table: FAILED **");
            $finish;
        end
    end

endmodule
